[src/lsp_pkg.sv]
// ---------------------------------------------------------------------------
// lsp_pkg
// Types and codes shared by the positional-insert stack.
// ---------------------------------------------------------------------------
package lsp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
        logic [4:0]         position;
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [4:0]         entry_count;
    } rsp_item_t;

endpackage

[src/lifo_stack_positional_insert.sv]
// ---------------------------------------------------------------------------
// lifo_stack_positional_insert
// Bounded LIFO of signed 32-bit words with push, pop and insert-at-depth.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid/cmd_ready/cmd_item) carries one item per
//   command: push on top, pop the top, or insert at a depth counted from
//   the top (0 = top; a depth at or past the fill count inserts at the
//   bottom). Response channel (rsp_valid/rsp_ready/rsp_item) returns one
//   item per command: the popped word (zero otherwise), a status code and
//   the fill count after the command.
//   The item lands in the input register at the accept edge and its
//   response is then registered in the result register. Throughput: 1
//   item per cycle while rsp_ready stays high; the whole update (parallel
//   shift of all entries above the insert point, or the top read) is one
//   level of logic between the input register and the result register.
//   Reset: fill count cleared, both registers empty. Entry storage is not
//   cleared; only entries below the fill count are ever read.
//   Stall: while rsp_ready is low the response holds, the input register
//   keeps its item, and cmd_ready drops once the input register is full.
// ---------------------------------------------------------------------------
module lifo_stack_positional_insert (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  lsp_pkg::cmd_item_t cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output lsp_pkg::rsp_item_t rsp_item
);
    import lsp_pkg::*;

    // Input stage
    logic      in_valid_reg;
    cmd_item_t in_item_reg;

    // Result stage
    logic      rsp_valid_reg;
    rsp_item_t rsp_item_reg;
    rsp_item_t rsp_item_next;

    // Stack state; entry 0 is the bottom
    logic signed [31:0] entries_reg  [STACK_DEPTH];
    logic signed [31:0] entries_next [STACK_DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               advance;
    logic [CNT_W-1:0]   ins_depth;
    logic [CNT_W-1:0]   ins_slot;
    logic [CNT_W-1:0]   top_pos;

    // Input stage moves forward whenever the result register is free or
    // is being drained this cycle.
    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_ready = !in_valid_reg || advance;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // Insert point: push always at depth 0, insert clamped to the bottom.
    always_comb
    begin
        if (in_item_reg.cmd == CMD_PUSH)
        begin
            ins_depth = '0;
        end
        else if (in_item_reg.position > count_reg)
        begin
            ins_depth = count_reg;
        end
        else
        begin
            ins_depth = in_item_reg.position;
        end
    end

    assign ins_slot = count_reg - ins_depth;
    assign top_pos  = count_reg - 1'b1;

    always_comb
    begin
        entries_next              = entries_reg;
        count_next                = count_reg;
        rsp_item_next.read_value  = '0;
        rsp_item_next.status      = ST_DONE;

        case (in_item_reg.cmd)
            CMD_PUSH, CMD_INSERT:
            begin
                if (count_reg >= CNT_W'(STACK_DEPTH))
                begin
                    rsp_item_next.status = ST_FULL;
                end
                else
                begin
                    // Entries from the slot up to the old top move one up.
                    for (int k = 0; k < STACK_DEPTH; k++)
                    begin
                        if (CNT_W'(k) == ins_slot)
                        begin
                            entries_next[k] = in_item_reg.value;
                        end
                        else if ((CNT_W'(k) > ins_slot) && (CNT_W'(k) <= count_reg) && (k > 0))
                        begin
                            entries_next[k] = entries_reg[(k > 0) ? k - 1 : 0];
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP:
            begin
                if (count_reg == '0)
                begin
                    rsp_item_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_item_next.read_value = entries_reg[top_pos[IDX_W-1:0]];
                    count_next               = top_pos;
                end
            end
            default:
            begin
                // Unused command code: no change, plain done response.
            end
        endcase

        rsp_item_next.entry_count = 5'(count_next);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (cmd_ready)
            begin
                in_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and storage
    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            in_item_reg <= cmd_item;
        end
        if (advance)
        begin
            rsp_item_reg <= rsp_item_next;
            entries_reg  <= entries_next;
        end
    end

    // Fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("fill count above stack depth");

    // A successful pop lowers the fill count by exactly one.
    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.cmd == CMD_POP) && (count_reg != '0)
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not lower fill count");

    // A full rejection reports a full stack.
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_item_reg.status == ST_FULL)
        |-> rsp_item_reg.entry_count == 5'(STACK_DEPTH))
        else $error("full status with stack not full");

    // An empty rejection reports an empty stack.
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_item_reg.status == ST_EMPTY)
        |-> rsp_item_reg.entry_count == '0)
        else $error("empty status with stack not empty");

    // Rejected commands never return a word.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_item_reg.status != ST_DONE)
        |-> rsp_item_reg.read_value == '0)
        else $error("rejected command returned a word");

endmodule

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the positional-insert LIFO. Drives push, pop,
// insert-at-depth and unused command items with random gaps, stalls the
// response side at random, and checks every response against an in-bench
// model of the stack.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsp_pkg::*;

    // Code 3 is not an operation; the block must leave the stack alone.
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         RANDOM_CMDS = 450;
    localparam int         DRAIN_WAIT  = 10;
    localparam int         CYCLE_LIMIT = 200000;

    typedef enum int { PH_FILL, PH_DRAIN, PH_MIX } phase_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_item_t cmd_item  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp_item;

    // Command items waiting to go out, and responses the model predicts.
    cmd_item_t pending_cmds[$];
    rsp_item_t expected_rsps[$];

    // Model of the stack: slot 0 is the bottom.
    logic signed [31:0] model_words [STACK_DEPTH];
    int                 model_count = 0;

    int mismatches = 0;
    int rsp_seen   = 0;
    int cycle_cnt  = 0;

    // Idle shaping for both channels.
    int cmd_gap  = 0;
    int cmd_calm = 0;
    int rsp_hold = 0;
    int rsp_calm = 0;

    lifo_stack_positional_insert u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    always #1ns clk = ~clk;

    // Apply one command to the model and return the response it must cause.
    function automatic rsp_item_t stack_apply(input cmd_item_t c);
        rsp_item_t r;
        int        depth;
        int        slot;
        r        = '0;
        r.status = ST_DONE;
        case (c.cmd)
            CMD_PUSH, CMD_INSERT:
            begin
                if (model_count >= STACK_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // push is an insert at depth 0; deep positions clamp
                    // to the bottom
                    depth = (c.cmd == CMD_PUSH) ? 0 : int'(c.position);
                    if (depth > model_count)
                        depth = model_count;
                    slot = model_count - depth;
                    for (int k = model_count; k > slot; k--)
                        model_words[k] = model_words[k - 1];
                    model_words[slot] = c.value;
                    model_count++;
                end
            end
            CMD_POP:
            begin
                if (model_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    model_count--;
                    r.read_value = model_words[model_count];
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = 5'(model_count);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random word with extra weight on the corners of the signed range.
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Insert depth: mostly within the live range, some past the bottom.
    function automatic logic [4:0] rand_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 5'($urandom_range(0, 16));
        if (r < 80)
            return 5'($urandom_range(0, 3));
        return 5'($urandom_range(17, 31));
    endfunction

    task automatic queue_cmd(input logic [1:0] c, input logic signed [31:0] v,
                             input logic [4:0] p);
        cmd_item_t it;
        it.cmd      = c;
        it.value    = v;
        it.position = p;
        pending_cmds.push_back(it);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at response %0d: %s expected %0h got %0h",
                 rsp_seen, what, want, got);
        mismatches++;
    endtask

    // -----------------------------------------------------------------------
    // Command driver. An item accepted at this edge is run through the model
    // right away, so expectations line up with acceptance order. The next
    // item goes out after a random gap; while an item is offered nothing
    // on the bus changes.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic accepted;
        logic offering;
        accepted = cmd_valid && cmd_ready;
        offering = cmd_valid && !accepted;
        if (rst_n)
        begin
            if (accepted)
                expected_rsps.push_back(stack_apply(cmd_item));
            if (!offering)
            begin
                if (cmd_gap > 0)
                begin
                    cmd_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_item  <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                    // calm stretches give back-to-back items
                    if (cmd_calm > 0)
                    begin
                        cmd_calm--;
                        cmd_gap = 0;
                    end
                    else
                    begin
                        cmd_gap = idle_len();
                        if ($urandom_range(0, 39) == 0)
                            cmd_calm = $urandom_range(20, 50);
                    end
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Response monitor. Compares each accepted response with the oldest
    // expectation, then decides whether to stall the next cycle.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    report_mismatch("unexpected response", 32'd0, 32'(rsp_item));
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_item.read_value !== want.read_value)
                        report_mismatch("read_value", want.read_value,
                                        rsp_item.read_value);
                    if (rsp_item.status !== want.status)
                        report_mismatch("status", 32'(want.status),
                                        32'(rsp_item.status));
                    if (rsp_item.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(want.entry_count),
                                        32'(rsp_item.entry_count));
                end
                rsp_seen++;
            end
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (rsp_calm > 0)
                    rsp_calm--;
                else if ($urandom_range(0, 99) < 25)
                    rsp_hold = idle_len();
                else if ($urandom_range(0, 59) == 0)
                    rsp_calm = $urandom_range(30, 80);
            end
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL lifo_stack_positional_insert");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run.
    // -----------------------------------------------------------------------
    initial
    begin
        phase_t ph;
        int     len;
        int     r;
        int     add_pct;
        int     made;
        logic [1:0] c;

        // Directed: pop on empty, signed extremes, insert at top, one down,
        // exactly at the bottom and far past it, the unused code, then drain
        // past empty so every entry comes back in order.
        queue_cmd(CMD_POP,    rand_word(),   5'd0);
        queue_cmd(CMD_PUSH,   32'sh7FFF_FFFF, 5'd31);
        queue_cmd(CMD_PUSH,   32'sh8000_0000, 5'd0);
        queue_cmd(CMD_INSERT, 32'shFFFF_FFFF, 5'd0);
        queue_cmd(CMD_INSERT, 32'sh0000_0000, 5'd1);
        queue_cmd(CMD_INSERT, 32'sh5555_5555, 5'd31);
        queue_cmd(CMD_INSERT, 32'shAAAA_AAAA, 5'd5);
        queue_cmd(CMD_INSERT, 32'sh1234_5678, 5'd16);
        queue_cmd(CMD_UNUSED, 32'shDEAD_BEEF, 5'd7);
        queue_cmd(CMD_PUSH,   rand_word(),   5'd0);
        for (int i = 0; i < 9; i++)
            queue_cmd(CMD_POP, rand_word(), rand_position());
        queue_cmd(CMD_POP,    32'shFFFF_FFFF, 5'd31);
        queue_cmd(CMD_UNUSED, 32'sh0000_0000, 5'd0);

        // Random: alternating fill, drain and mixed phases so that the full
        // and empty edges are hit many times over.
        made = 0;
        while (made < RANDOM_CMDS)
        begin
            ph  = phase_t'($urandom_range(0, 2));
            len = $urandom_range(10, 30);
            case (ph)
                PH_FILL:  add_pct = 85;
                PH_DRAIN: add_pct = 15;
                default:  add_pct = 50;
            endcase
            for (int j = 0; j < len; j++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    c = CMD_UNUSED;
                else if ($urandom_range(0, 99) < add_pct)
                    c = ($urandom_range(0, 1) == 0) ? CMD_PUSH : CMD_INSERT;
                else
                    c = CMD_POP;
                queue_cmd(c, rand_word(), 5'($urandom_range(0, 31)) &
                          ((c == CMD_INSERT) ? rand_position() : 5'h1F));
                made++;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || cmd_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_rsps.size() != 0)
            report_mismatch("missing responses", 32'(expected_rsps.size()), 32'd0);

        if (mismatches == 0)
            $display("PASS lifo_stack_positional_insert");
        else
            $display("FAIL lifo_stack_positional_insert");
        $finish;
    end

endmodule

[filelist.f]
src/lsp_pkg.sv
src/lifo_stack_positional_insert.sv
sim/tb.sv
